// ===== hw/rtl/pfcv_pkg.sv =====
// Package for the pose frame conversion block: shared types and constants.
// Used by the interfaces' users, the front, queue, divider, back and top level.
package pfcv_pkg;

   typedef logic signed [32:0] wide_type;
   typedef logic signed [31:0] word_type;

   // One classified sample, handed from the front to the back.
   typedef struct packed {
      wide_type [3:0] enu_vec;   // (qz+qx, qx-qz, qw+qy, qw-qy)
      wide_type [3:0] ned_vec;   // (qx, qz, -qy, qw)
      word_type [2:0] enu_pos;   // east, north, up
      word_type [2:0] ned_pos;   // north, east, down
      wide_type [2:0] diff;      // ENU position minus previous ENU position
      logic [47:0]    dt;
      logic           valid;
   } job_type;

   localparam logic DIV_MODE_QUAT = 1'b0;
   localparam logic DIV_MODE_VEL  = 1'b1;

   typedef struct packed {
      logic        start;
      logic        mode;
      logic [63:0] num;
      logic [47:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [32:0] quot;
   } div_rsp_type;

   localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
   localparam logic [32:0] US_PER_S  = 33'd1000000;
   localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_MIN  = 32'h8000_0000;

endpackage

// ===== hw/rtl/pfcv_if.sv =====
// Handshake channel interfaces for the pose frame conversion block.
// Request carries one pose sample, response carries one converted result.
interface pfcv_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] time_us;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] quat_x;
   logic signed [31:0] quat_y;
   logic signed [31:0] quat_z;
   logic signed [31:0] quat_w;
   modport source (output valid, time_us, pos_x, pos_y, pos_z,
                   quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, time_us, pos_x, pos_y, pos_z,
                   quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface pfcv_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [31:0] orient_x;
   logic signed [31:0] orient_y;
   logic signed [31:0] orient_z;
   logic signed [31:0] orient_w;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic        vel_valid;
   modport source (output valid, frame, out_x, out_y, out_z, orient_x, orient_y,
                   orient_z, orient_w, vel_x, vel_y, vel_z, vel_valid, input ready);
   modport sink   (input valid, frame, out_x, out_y, out_z, orient_x, orient_y,
                   orient_z, orient_w, vel_x, vel_y, vel_z, vel_valid, output ready);
endinterface

// ===== hw/rtl/pfcv_front.sv =====
// Front of the pose frame conversion block: accepts samples, keeps the
// previous ENU sample and builds jobs for the queue. Depends on pfcv_pkg.
module pfcv_front
   import pfcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pfcv_req_if.sink    req,
   input  logic [15:0] min_dt,
   input  logic        queue_full,
   output logic        push,
   output job_type     job
);

   logic [31:0] prev_east_ff, prev_north_ff, prev_up_ff;
   logic [47:0] prev_time_ff;
   logic        have_prev_ff;
   logic [48:0] dt_full;
   wide_type    qx, qy, qz, qw;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      qx = {req.quat_x[31], req.quat_x};
      qy = {req.quat_y[31], req.quat_y};
      qz = {req.quat_z[31], req.quat_z};
      qw = {req.quat_w[31], req.quat_w};
      dt_full = {1'b0, req.time_us} - {1'b0, prev_time_ff};

      job.enu_vec[0] = qz + qx;
      job.enu_vec[1] = qx - qz;
      job.enu_vec[2] = qw + qy;
      job.enu_vec[3] = qw - qy;
      job.ned_vec[0] = qx;
      job.ned_vec[1] = qz;
      job.ned_vec[2] = 33'sd0 - qy;
      job.ned_vec[3] = qw;
      job.enu_pos[0] = req.pos_z;
      job.enu_pos[1] = req.pos_x;
      job.enu_pos[2] = req.pos_y;
      job.ned_pos[0] = req.pos_x;
      job.ned_pos[1] = req.pos_z;
      // Negating the most negative value saturates.
      job.ned_pos[2] = (req.pos_y == WORD_MIN) ? WORD_MAX : 32'sd0 - req.pos_y;
      job.diff[0] = {req.pos_z[31], req.pos_z} - {prev_east_ff[31], prev_east_ff};
      job.diff[1] = {req.pos_x[31], req.pos_x} - {prev_north_ff[31], prev_north_ff};
      job.diff[2] = {req.pos_y[31], req.pos_y} - {prev_up_ff[31], prev_up_ff};
      job.dt    = dt_full[47:0];
      job.valid = have_prev_ff && !dt_full[48] && (dt_full[47:0] > {32'd0, min_dt});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_east_ff  <= '0;
         prev_north_ff <= '0;
         prev_up_ff    <= '0;
         prev_time_ff  <= '0;
         have_prev_ff  <= 1'b0;
      end else if (push) begin
         prev_east_ff  <= req.pos_z;
         prev_north_ff <= req.pos_x;
         prev_up_ff    <= req.pos_y;
         prev_time_ff  <= req.time_us;
         have_prev_ff  <= 1'b1;
      end
   end

endmodule

// ===== hw/rtl/pfcv_queue.sv =====
// Two-entry job queue between the front and the back.
// Depends on pfcv_pkg for the job type.
module pfcv_queue
   import pfcv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    full,
   output logic    empty
);

   job_type     mem_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

// ===== hw/rtl/pfcv_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on pfcv_pkg; the caller guarantees the quotient fits the mode.
module pfcv_divider
   import pfcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [48:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [32:0] quot_ff, quot_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [48:0] trial;

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[47:0], dsr_ff[63]};
      if (div_req.start) begin
         busy_in = 1'b1;
         quot_in = '0;
         if (div_req.mode == DIV_MODE_QUAT) begin
            rem_in = {16'd0, div_req.num[63:31]};
            dsr_in = {div_req.num[30:0], 33'd0};
            cnt_in = 6'd31;
         end else begin
            rem_in = {18'd0, div_req.num[63:33]};
            dsr_in = {div_req.num[32:0], 31'd0};
            cnt_in = 6'd33;
         end
      end else if (busy_ff) begin
         dsr_in = {dsr_ff[62:0], 1'b0};
         if (trial >= {1'b0, div_req.den}) begin
            rem_in  = trial - {1'b0, div_req.den};
            quot_in = {quot_ff[31:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== hw/rtl/pfcv_back.sv =====
// Back of the pose frame conversion block: normalizes both quaternions,
// computes the velocity and drives the result register. Uses pfcv_pkg.
module pfcv_back
   import pfcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  job_type     queue_job,
   output logic        pop,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   pfcv_rsp_if.source  rsp
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_NLOAD  = 4'd1;
   localparam logic [3:0] S_NSHIFT = 4'd2;
   localparam logic [3:0] S_SQMUL  = 4'd3;
   localparam logic [3:0] S_SQACC  = 4'd4;
   localparam logic [3:0] S_SQRT   = 4'd5;
   localparam logic [3:0] S_QDIV   = 4'd6;
   localparam logic [3:0] S_QWAIT  = 4'd7;
   localparam logic [3:0] S_VMUL   = 4'd8;
   localparam logic [3:0] S_VADD   = 4'd9;
   localparam logic [3:0] S_VDIV   = 4'd10;
   localparam logic [3:0] S_VWAIT  = 4'd11;
   localparam logic [3:0] S_EMIT   = 4'd12;

   logic [3:0]        state_ff, state_in;
   job_type           job_ff, job_in;
   logic              frame_ff, frame_in;
   logic [1:0]        idx_ff, idx_in;
   logic [3:0][32:0]  m_ff, m_in;
   logic [3:0]        neg_ff, neg_in;
   logic [59:0]       prod_ff, prod_in;
   logic [61:0]       acc_ff, acc_in;
   logic [61:0]       sq_s_ff, sq_s_in;
   logic [33:0]       sq_rem_ff, sq_rem_in;
   logic [30:0]       root_ff, root_in;
   logic [4:0]        sq_cnt_ff, sq_cnt_in;
   logic [3:0][31:0]  orient_ff, orient_in;
   logic [2:0][31:0]  vel_ff, vel_in;
   logic              vneg_ff, vneg_in;
   logic [53:0]       num_ff, num_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              r_frame_ff, r_frame_in, r_vv_ff, r_vv_in;
   logic [2:0][31:0]  r_pos_ff, r_pos_in;
   logic [3:0][31:0]  r_orient_ff, r_orient_in;
   logic [2:0][31:0]  r_vel_ff, r_vel_in;

   wide_type          vsel;
   logic [32:0]       m_or;
   logic [32:0]       mul_a, mul_b;
   logic [65:0]       mul_p;
   logic [33:0]       sq_sh, sq_trial;
   logic [32:0]       dmag;
   logic              out_free;
   logic              vel_on;

   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign mul_p        = mul_a * mul_b;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.frame    = r_frame_ff;
   assign rsp.out_x    = r_pos_ff[0];
   assign rsp.out_y    = r_pos_ff[1];
   assign rsp.out_z    = r_pos_ff[2];
   assign rsp.orient_x = r_orient_ff[0];
   assign rsp.orient_y = r_orient_ff[1];
   assign rsp.orient_z = r_orient_ff[2];
   assign rsp.orient_w = r_orient_ff[3];
   assign rsp.vel_x    = r_vel_ff[0];
   assign rsp.vel_y    = r_vel_ff[1];
   assign rsp.vel_z    = r_vel_ff[2];
   assign rsp.vel_valid = r_vv_ff;

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      frame_in   = frame_ff;
      idx_in     = idx_ff;
      m_in       = m_ff;
      neg_in     = neg_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      sq_s_in    = sq_s_ff;
      sq_rem_in  = sq_rem_ff;
      root_in    = root_ff;
      sq_cnt_in  = sq_cnt_ff;
      orient_in  = orient_ff;
      vel_in     = vel_ff;
      vneg_in    = vneg_ff;
      num_in     = num_ff;
      r_frame_in = r_frame_ff;
      r_vv_in    = r_vv_ff;
      r_pos_in   = r_pos_ff;
      r_orient_in = r_orient_ff;
      r_vel_in   = r_vel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pop        = 1'b0;
      div_req.start = 1'b0;
      div_req.mode  = DIV_MODE_QUAT;
      div_req.num   = 64'({m_ff[idx_ff][29:0], 30'd0}) + 64'(root_ff[30:1]);
      div_req.den   = 48'(root_ff);
      mul_a = m_ff[idx_ff];
      mul_b = m_ff[idx_ff];
      m_or  = m_ff[0] | m_ff[1] | m_ff[2] | m_ff[3];
      vsel  = frame_ff ? job_ff.ned_vec[idx_ff] : job_ff.enu_vec[idx_ff];
      sq_sh = {sq_rem_ff[31:0], sq_s_ff[61:60]};
      sq_trial = {1'b0, root_ff, 2'b01};
      dmag  = job_ff.diff[idx_ff][32] ? 33'(-job_ff.diff[idx_ff]) : 33'(job_ff.diff[idx_ff]);
      vel_on = !frame_ff && job_ff.valid;

      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               job_in   = queue_job;
               frame_in = 1'b0;
               idx_in   = 2'd0;
               state_in = S_NLOAD;
            end
         end
         // Takes one component's magnitude and sign per cycle.
         S_NLOAD: begin
            m_in[idx_ff]   = vsel[32] ? 33'(-vsel) : 33'(vsel);
            neg_in[idx_ff] = vsel[32];
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) state_in = S_NSHIFT;
         end
         S_NSHIFT: begin
            idx_in = 2'd0;
            if (m_or == 33'd0) begin
               orient_in[0] = '0;
               orient_in[1] = '0;
               orient_in[2] = '0;
               orient_in[3] = Q30_ONE;
               state_in = vel_on ? S_VMUL : S_EMIT;
            end else if (m_or[32:30] != 3'd0) begin
               for (int i = 0; i < 4; i++) m_in[i] = {1'b0, m_ff[i][32:1]};
            end else if (!m_or[29]) begin
               for (int i = 0; i < 4; i++) m_in[i] = {m_ff[i][31:0], 1'b0};
            end else begin
               acc_in   = '0;
               state_in = S_SQMUL;
            end
         end
         S_SQMUL: begin
            prod_in  = mul_p[59:0];
            state_in = S_SQACC;
         end
         S_SQACC: begin
            acc_in = acc_ff + 62'(prod_ff);
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               sq_s_in   = acc_ff + 62'(prod_ff);
               sq_rem_in = '0;
               root_in   = '0;
               sq_cnt_in = '0;
               state_in  = S_SQRT;
            end else begin
               state_in = S_SQMUL;
            end
         end
         // Integer square root, two radicand bits per cycle.
         S_SQRT: begin
            sq_s_in = {sq_s_ff[59:0], 2'b00};
            if (sq_sh >= sq_trial) begin
               sq_rem_in = sq_sh - sq_trial;
               root_in   = {root_ff[29:0], 1'b1};
            end else begin
               sq_rem_in = sq_sh;
               root_in   = {root_ff[29:0], 1'b0};
            end
            sq_cnt_in = sq_cnt_ff + 5'd1;
            if (sq_cnt_ff == 5'd30) begin
               idx_in   = 2'd0;
               state_in = S_QDIV;
            end
         end
         S_QDIV: begin
            div_req.start = 1'b1;
            state_in = S_QWAIT;
         end
         S_QWAIT: begin
            if (div_rsp.done) begin
               orient_in[idx_ff] = neg_ff[idx_ff] ? 32'(-div_rsp.quot)
                                                  : div_rsp.quot[31:0];
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  idx_in   = 2'd0;
                  state_in = vel_on ? S_VMUL : S_EMIT;
               end else begin
                  state_in = S_QDIV;
               end
            end
         end
         S_VMUL: begin
            mul_a    = dmag;
            mul_b    = US_PER_S;
            prod_in  = mul_p[59:0];
            vneg_in  = job_ff.diff[idx_ff][32];
            state_in = S_VADD;
         end
         S_VADD: begin
            // Half the divisor is added so that truncation rounds to nearest.
            num_in   = prod_ff[53:0] + 54'(job_ff.dt[47:1]);
            state_in = S_VDIV;
         end
         S_VDIV: begin
            div_req.mode = DIV_MODE_VEL;
            div_req.num  = 64'(num_ff);
            div_req.den  = job_ff.dt;
            if ({27'd0, num_ff[53:33]} >= job_ff.dt) begin
               // Quotient of 2^33 or more saturates without a division.
               vel_in[idx_ff] = vneg_ff ? WORD_MIN : WORD_MAX;
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd2) ? S_EMIT : S_VMUL;
            end else begin
               div_req.start = 1'b1;
               state_in = S_VWAIT;
            end
         end
         S_VWAIT: begin
            div_req.mode = DIV_MODE_VEL;
            div_req.num  = 64'(num_ff);
            div_req.den  = job_ff.dt;
            if (div_rsp.done) begin
               if (vneg_ff) begin
                  vel_in[idx_ff] = (div_rsp.quot > 33'h0_8000_0000) ? WORD_MIN
                                                                   : 32'(-div_rsp.quot);
               end else begin
                  vel_in[idx_ff] = (div_rsp.quot > 33'h0_7FFF_FFFF) ? WORD_MAX
                                                                   : div_rsp.quot[31:0];
               end
               idx_in   = idx_ff + 2'd1;
               state_in = (idx_ff == 2'd2) ? S_EMIT : S_VMUL;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               r_frame_in   = frame_ff;
               r_vv_in      = vel_on;
               r_pos_in     = frame_ff ? job_ff.ned_pos : job_ff.enu_pos;
               r_orient_in  = orient_ff;
               for (int i = 0; i < 3; i++) r_vel_in[i] = vel_on ? vel_ff[i] : 32'd0;
               idx_in = 2'd0;
               if (!frame_ff) begin
                  frame_in = 1'b1;
                  state_in = S_NLOAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      frame_ff    <= frame_in;
      idx_ff      <= idx_in;
      m_ff        <= m_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      sq_s_ff     <= sq_s_in;
      sq_rem_ff   <= sq_rem_in;
      root_ff     <= root_in;
      sq_cnt_ff   <= sq_cnt_in;
      orient_ff   <= orient_in;
      vel_ff      <= vel_in;
      vneg_ff     <= vneg_in;
      num_ff      <= num_in;
      r_frame_ff  <= r_frame_in;
      r_vv_ff     <= r_vv_in;
      r_pos_ff    <= r_pos_in;
      r_orient_ff <= r_orient_in;
      r_vel_ff    <= r_vel_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/pose_frame_convert_velocity_top.sv =====
// Pose frame conversion top level: front, job queue, back and shared divider.
// The ENU result of a sample is emitted first and its NED result follows. Time goes to serial
// normalizing shifts, a 31-step square root, one quaternion division per component and a
// velocity division per axis unless it saturates. The front accepts new samples while the back
// works on earlier ones; two samples can wait in the queue. Reset sets min_dt_us to 1.
module pose_frame_convert_velocity_top
   import pfcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pfcv_req_if.sink    req,
   pfcv_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // The only register, min_dt_us, lives at byte address zero. A write to the
   // upper word of the address space is dropped.
   logic [15:0] min_dt_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {16'd0, min_dt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dt_ff <= 16'd1;
      end else if (csr_write && !csr_paddr[2]) begin
         min_dt_ff <= csr_pwdata[15:0];
      end
   end

   // The front classifies each transfer at once and updates the previous
   // sample; the back then works through the job on its own schedule.
   job_type     push_job, pop_job;
   logic        push, pop, queue_full, queue_empty;
   div_req_type div_req;
   div_rsp_type div_rsp;

   pfcv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .min_dt     (min_dt_ff),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   pfcv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // One divider serves both the quaternion scaling and the velocity.
   pfcv_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // The back emits the ENU result and then the NED result of every job through its output
   // register; a waiting result holds the back, and the front too once the queue is full.
   pfcv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_job   (pop_job),
      .pop         (pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp         (rsp)
   );

endmodule

// ===== bench/pose_frame_convert_velocity_top_test.sv =====
// Testbench for pose_frame_convert_velocity_top: drives pose samples, checks ENU and NED results.
// Depends on pfcv_pkg (hw/rtl/pfcv_pkg.sv), the channel interfaces (hw/rtl/pfcv_if.sv) and the RTL.
`timescale 1ns / 1ps

module pose_frame_convert_velocity_top_test;
   import pfcv_pkg::*;

   localparam logic [2:0] MIN_DT_ADDR = 3'd0;
   localparam logic FRAME_ENU = 1'b0;
   localparam logic FRAME_NED = 1'b1;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [47:0] time_us;
      logic signed [31:0] px, py, pz;
      logic signed [31:0] qx, qy, qz, qw;
   } pose_type;

   typedef struct {
      logic frame;
      logic signed [31:0] x, y, z;
      logic signed [31:0] ox, oy, oz, ow;
      logic signed [31:0] vx, vy, vz;
      logic vel_valid;
   } frame_result_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   pfcv_req_if req ();
   pfcv_rsp_if rsp ();

   pose_frame_convert_velocity_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Predictor state: its own copy of the tracker history and of the register.
   logic [15:0] model_min_dt;
   longint model_prev_east, model_prev_north, model_prev_up;
   logic [47:0] model_prev_time;
   bit model_have_prev;

   frame_result_type expected_results[$];
   int mismatch_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_cycles;
   int quiet_cycles;

   // Stimulus-side history, so that random sequences move smoothly.
   logic [47:0] stim_time;
   logic signed [31:0] stim_px, stim_py, stim_pz;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Block-scaled normalization of a four-component integer quaternion.
   task automatic normalize_quat(input longint v[4], output logic signed [31:0] o[4]);
      logic [63:0] m[4];
      logic [63:0] mx, s, n, q;
      int up, down;
      mx = 0;
      s = 0;
      up = 0;
      down = 0;
      for (int i = 0; i < 4; i++) begin
         m[i] = (v[i] < 0) ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0; o[3] = Q30_ONE;
         return;
      end
      while (mx >= (64'd1 << 30)) begin mx = mx >> 1; down++; end
      while (mx < (64'd1 << 29)) begin mx = mx << 1; up++; end
      for (int i = 0; i < 4; i++) begin
         m[i] = (m[i] >> down) << up;
         s = s + m[i] * m[i];
      end
      n = int_sqrt(s);
      for (int i = 0; i < 4; i++) begin
         q = ((m[i] << 30) + (n >> 1)) / n;
         o[i] = (v[i] < 0) ? -q[31:0] : q[31:0];
      end
   endtask

   function automatic logic signed [31:0] rate_of_change(longint now, longint prev,
                                                          logic [63:0] dt);
      longint d;
      logic [63:0] mag, q;
      d = now - prev;
      mag = ((d < 0) ? -d : d) * 64'd1000000;
      q = (mag + (dt >> 1)) / dt;
      if (d < 0) return (q > 64'h8000_0000) ? WORD_MIN : -q[31:0];
      return (q > 64'h7FFF_FFFF) ? WORD_MAX : q[31:0];
   endfunction

   // Works out the ENU and NED results of one accepted sample and advances the history.
   task automatic predict_frames(input pose_type p);
      frame_result_type enu, ned;
      longint v[4];
      logic signed [31:0] o[4];
      longint dt;
      bit vel_ok;
      dt = longint'({16'd0, p.time_us}) - longint'({16'd0, model_prev_time});
      vel_ok = model_have_prev && dt > longint'({48'd0, model_min_dt});

      enu.frame = FRAME_ENU;
      enu.x = p.pz; enu.y = p.px; enu.z = p.py;
      enu.vx = 0; enu.vy = 0; enu.vz = 0;
      enu.vel_valid = vel_ok;
      if (vel_ok) begin
         enu.vx = rate_of_change(p.pz, model_prev_east, dt);
         enu.vy = rate_of_change(p.px, model_prev_north, dt);
         enu.vz = rate_of_change(p.py, model_prev_up, dt);
      end
      v[0] = longint'(p.qz) + p.qx; v[1] = longint'(p.qx) - p.qz;
      v[2] = longint'(p.qw) + p.qy; v[3] = longint'(p.qw) - p.qy;
      normalize_quat(v, o);
      enu.ox = o[0]; enu.oy = o[1]; enu.oz = o[2]; enu.ow = o[3];

      ned.frame = FRAME_NED;
      ned.x = p.px; ned.y = p.pz;
      ned.z = (p.py == WORD_MIN) ? WORD_MAX : -p.py;
      ned.vx = 0; ned.vy = 0; ned.vz = 0;
      ned.vel_valid = 1'b0;
      v[0] = p.qx; v[1] = p.qz; v[2] = -longint'(p.qy); v[3] = p.qw;
      normalize_quat(v, o);
      ned.ox = o[0]; ned.oy = o[1]; ned.oz = o[2]; ned.ow = o[3];

      expected_results.push_back(enu);
      expected_results.push_back(ned);
      model_prev_east = p.pz;
      model_prev_north = p.px;
      model_prev_up = p.py;
      model_prev_time = p.time_us;
      model_have_prev = 1'b1;
   endtask

   // Sends one sample, with a random gap before it, and predicts at the transfer.
   task automatic send_sample(input pose_type p);
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req.valid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.time_us <= p.time_us;
      req.pos_x <= p.px; req.pos_y <= p.py; req.pos_z <= p.pz;
      req.quat_x <= p.qx; req.quat_y <= p.qy; req.quat_z <= p.qz; req.quat_w <= p.qw;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_frames(p);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      stop_sending();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Writes min_dt_us through the configuration port; only called while the block is idle.
   task automatic write_min_dt(input logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= MIN_DT_ADDR;
      csr_pwdata <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      model_min_dt = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic signed [31:0] any_word();
      return $urandom();
   endfunction

   // A quaternion with random content: full range, components within unit range, or zero.
   function automatic pose_type random_quat(pose_type p);
      int kind;
      kind = $urandom_range(9);
      if (kind < 4) begin
         p.qx = any_word(); p.qy = any_word(); p.qz = any_word(); p.qw = any_word();
      end else if (kind < 9) begin
         p.qx = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
         p.qy = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
         p.qz = $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
         p.qw = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
      end else begin
         p.qx = 0; p.qy = 0; p.qz = 0; p.qw = 0;
      end
      return p;
   endfunction

   // Next sample of a plausible track; now and then a jump, a stall or a step backward.
   function automatic pose_type next_track_sample();
      pose_type p;
      int kind;
      kind = $urandom_range(99);
      if (kind < 75) begin
         stim_time = stim_time + $urandom_range(1, 20000);
         stim_px = stim_px + $signed($urandom_range(2000000)) - 1000000;
         stim_py = stim_py + $signed($urandom_range(2000000)) - 1000000;
         stim_pz = stim_pz + $signed($urandom_range(2000000)) - 1000000;
      end else if (kind < 85) begin
         stim_time = stim_time + $urandom_range(0, 3);
         stim_px = any_word(); stim_py = any_word(); stim_pz = any_word();
      end else if (kind < 92) begin
         stim_time = stim_time - $urandom_range(0, 1000);
      end else begin
         stim_time = 48'({$urandom(), $urandom()});
         stim_px = any_word(); stim_py = any_word(); stim_pz = any_word();
      end
      p.time_us = stim_time;
      p.px = stim_px; p.py = stim_py; p.pz = stim_pz;
      return random_quat(p);
   endfunction

   function automatic pose_type make_pose(logic [47:0] t, logic signed [31:0] px, py, pz,
                                          logic signed [31:0] qx, qy, qz, qw);
      pose_type p;
      p.time_us = t;
      p.px = px; p.py = py; p.pz = pz;
      p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
      return p;
   endfunction

   // Field extremes, the first sample with no history, a zero quaternion, the NED down
   // overflow, time that stands still or runs backward, and saturating velocity.
   task automatic test_directed_cases();
      send_sample(make_pose(48'd0, 0, 0, 0, 0, 0, 0, 0));
      send_sample(make_pose(48'd1, 0, 0, 0, 0, 0, 0, Q30_ONE));
      send_sample(make_pose(48'd3, WORD_MAX, WORD_MIN, WORD_MAX,
                            WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
      send_sample(make_pose(48'd5, WORD_MIN, WORD_MAX, WORD_MIN,
                            WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
      send_sample(make_pose(48'd5, 1, -1, 2, 1, 0, 0, 0));
      send_sample(make_pose(48'd4, 7, 8, 9, 0, 1, 0, 0));
      send_sample(make_pose(48'd1004, 65536, -65536, 0, 0, 0, 1, 0));
      send_sample(make_pose(48'hFFFF_FFFF_FFFF, 0, WORD_MIN, 0,
                            Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE));
      send_sample(make_pose(48'h8000_0000_0000, -3, 3, -3, -1, -1, -1, -1));
      send_sample(make_pose(48'h8000_0000_0002, 100, -100, 50,
                            32'sh2D41_3CCD, 0, 32'sh2D41_3CCD, 0));
      send_sample(make_pose(48'h8000_0000_0003, 101, -101, 50, 3, -5, 7, -11));
      wait_drained();
   endtask

   // Velocity gating around min_dt_us at its extremes and at a middle value.
   task automatic test_min_dt_settings();
      logic [15:0] settings[4];
      settings[0] = 16'd0;
      settings[1] = 16'hFFFF;
      settings[2] = 16'($urandom_range(2, 65534));
      settings[3] = 16'd1;
      foreach (settings[i]) begin
         write_min_dt(settings[i]);
         stim_time = stim_time + 1;
         send_sample(make_pose(stim_time, 10, 20, 30, 0, 0, 0, Q30_ONE));
         stim_time = stim_time + settings[i];
         send_sample(make_pose(stim_time, 11, 19, 31, 0, 0, 0, Q30_ONE));
         stim_time = stim_time + settings[i] + 1;
         send_sample(make_pose(stim_time, -500, 900, 31, 1, 2, 3, 4));
         stim_time = stim_time + 17;
         send_sample(make_pose(stim_time, 0, 0, 0, 5, 6, 7, 8));
         wait_drained();
      end
   endtask

   // Random tracks under one idling mix, with one register value for the phase.
   task automatic test_random_tracks(input int count, input int s_idle, input int r_idle,
                                     input logic [15:0] min_dt);
      write_min_dt(min_dt);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      repeat (count) send_sample(next_track_sample());
      wait_drained();
   endtask

   // The receiver holds off long enough that the queue fills and the input stalls;
   // afterwards the sender waits for every result before continuing.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_cycles = 2500;
      repeat (8) send_sample(next_track_sample());
      wait_drained();
      repeat (3) send_sample(next_track_sample());
      wait_drained();
   endtask

   // Receiver readiness: random idling, or a long hold-off counted down here.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compares each result transfer with the oldest expectation.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transfer: frame %0d x %0d", rsp.frame, rsp.out_x);
         end else begin
            want = expected_results.pop_front();
            if (rsp.frame !== want.frame || rsp.out_x !== want.x || rsp.out_y !== want.y ||
                rsp.out_z !== want.z || rsp.orient_x !== want.ox ||
                rsp.orient_y !== want.oy || rsp.orient_z !== want.oz ||
                rsp.orient_w !== want.ow || rsp.vel_x !== want.vx ||
                rsp.vel_y !== want.vy || rsp.vel_z !== want.vz ||
                rsp.vel_valid !== want.vel_valid) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected frame %0d pos %0d %0d %0d quat %0d %0d %0d %0d",
                           want.frame, want.x, want.y, want.z,
                           want.ox, want.oy, want.oz, want.ow);
                  $display("          vel %0d %0d %0d valid %0d",
                           want.vx, want.vy, want.vz, want.vel_valid);
                  $display("  actual: frame %0d pos %0d %0d %0d quat %0d %0d %0d %0d",
                           rsp.frame, rsp.out_x, rsp.out_y, rsp.out_z,
                           rsp.orient_x, rsp.orient_y, rsp.orient_z, rsp.orient_w);
                  $display("          vel %0d %0d %0d valid %0d",
                           rsp.vel_x, rsp.vel_y, rsp.vel_z, rsp.vel_valid);
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which no transfer happens on either channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pose_frame_convert_velocity_top test failed");
            $finish;
         end
      end
   end

   initial begin
      mismatch_count = 0;
      quiet_cycles = 0;
      hold_off_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      model_min_dt = 16'd1;
      model_prev_east = 0;
      model_prev_north = 0;
      model_prev_up = 0;
      model_prev_time = 0;
      model_have_prev = 1'b0;
      stim_time = 0;
      stim_px = 0; stim_py = 0; stim_pz = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.time_us = 0;
      req.pos_x = 0; req.pos_y = 0; req.pos_z = 0;
      req.quat_x = 0; req.quat_y = 0; req.quat_z = 0; req.quat_w = 0;
      rsp.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = MIN_DT_ADDR;
      csr_pwdata = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_min_dt_settings();
      test_random_tracks(330, 20, 80, 16'd0);
      test_backpressure();
      test_random_tracks(330, 80, 20, 16'($urandom_range(1, 5000)));
      test_random_tracks(330, 0, 0, 16'hFFFF);
      test_random_tracks(40, 0, 0, 16'd1);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("pose_frame_convert_velocity_top test passed");
      end else begin
         $display("pose_frame_convert_velocity_top test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pfcv_pkg.sv
hw/rtl/pfcv_if.sv
hw/rtl/pfcv_front.sv
hw/rtl/pfcv_queue.sv
hw/rtl/pfcv_divider.sv
hw/rtl/pfcv_back.sv
hw/rtl/pose_frame_convert_velocity_top.sv
bench/pose_frame_convert_velocity_top_test.sv
